>>> design/stlm_pkg.sv
// stlm_pkg: shared types and constants for the sorted timer list manager
// no dependencies
package stlm_pkg;

  localparam int DefNumSlots = 32;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_ARM   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_REPLY  = 2'd0,
    KIND_EXPIRY = 2'd1,
    KIND_TASK   = 2'd2
  } kind_t;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_SLOT   = 1'b1;

  // queued command between front and back
  typedef struct packed {
    cmd_t        command;
    logic [4:0]  slot;
    logic [31:0] delay_ticks;
    logic [3:0]  destination;
    logic [7:0]  payload;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  slot_out;
    logic        ok;
    logic [3:0]  dest_out;
    logic [7:0]  payload_out;
    logic        last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_TICK_HEAD,
    S_TASK_EMIT,
    S_UNLINK,
    S_INS_START,
    S_INS_WALK,
    S_REPLY
  } bstate_t;

endpackage

>>> design/stlm_fifo.sv
// stlm_fifo: two-entry command queue between front and back end
// depends on stlm_pkg
module stlm_fifo
  import stlm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t      mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wptr] <= in_item;
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (out_valid && out_ready) rptr <= ~rptr;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

endmodule

>>> design/stlm_engine.sv
// stlm_engine: back end that walks the sorted list and issues results
// depends on stlm_pkg
module stlm_engine
  import stlm_pkg::*;
#(
  parameter int NUM_SLOTS = DefNumSlots
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  input  logic    task_en,
  input  logic [4:0] task_slot,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res,
  output logic    busy
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int LW = IW + 1;
  localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);

  // per-slot store
  logic [31:0]   deadline [NUM_SLOTS];
  logic [3:0]    dst      [NUM_SLOTS];
  logic [7:0]    pay      [NUM_SLOTS];
  logic [LW-1:0] link     [NUM_SLOTS];
  logic [1:0]    status   [NUM_SLOTS];

  bstate_t       state, state_next;
  item_t         cur;
  logic [31:0]   now;
  logic [LW-1:0] head;
  logic [LW-1:0] p;
  logic [IW-1:0] tgt;
  logic [31:0]   tdl;
  logic [LW-1:0] guard;
  logic          ts_pend;
  logic          is_arm;
  logic          emitted;
  logic          reply_ok;
  logic [4:0]    reply_slot;

  logic [IW-1:0] hi, pi, li;
  logic [LW-1:0] q;
  logic          slot_in_range;
  logic [IW-1:0] cur_i;
  logic [IW-1:0] ts_i;
  logic [IW-1:0] free_i;
  logic          free_found;
  logic          slot_ok;
  logic          head_due;
  logic          hit_task;
  logic          ins_head;
  logic          ins_here;
  logic          unl_done;

  assign hi = head[IW-1:0];
  assign pi = p[IW-1:0];
  assign q  = link[pi];
  assign li = q[IW-1:0];
  assign slot_in_range = ({27'd0, cur.slot} < 32'(NUM_SLOTS));
  assign cur_i = IW'(cur.slot);
  assign ts_i  = IW'(task_slot);
  assign slot_ok  = slot_in_range && (status[cur_i] != ST_FREE);
  assign head_due = (guard != NIL) && (head != NIL) && (deadline[hi] <= now);
  assign hit_task = task_en && (32'(hi) == {27'd0, task_slot});
  assign ins_head = (head == NIL) || (tdl <= deadline[hi]);
  assign ins_here = (q == NIL) || (tdl <= deadline[li]);
  assign unl_done = (head == LW'(tgt)) || (p == NIL) || (q == LW'(tgt));

  always_comb begin
    free_i = '0;
    free_found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (status[i] == ST_FREE) begin
        free_i = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  // a waiting result does not hold off the next command
  assign in_ready = (state == S_IDLE);
  assign busy     = (state != S_IDLE) || res_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (cur.command)
          CMD_TICK:  state_next = S_TICK_HEAD;
          CMD_ALLOC: state_next = S_REPLY;
          default: begin
            if (!slot_ok) state_next = S_REPLY;
            else if (status[cur_i] == ST_RUN) state_next = S_UNLINK;
            else if (cur.command == CMD_ARM) state_next = S_INS_START;
            else state_next = S_REPLY;
          end
        endcase
      end
      S_TICK_HEAD: begin
        if (!res_valid && !head_due) state_next = ts_pend ? S_INS_START : S_IDLE;
      end
      S_UNLINK:    if (unl_done) state_next = is_arm ? S_INS_START : S_REPLY;
      S_INS_START: begin
        if (ins_head) state_next = ts_pend ? S_TASK_EMIT : S_REPLY;
        else state_next = S_INS_WALK;
      end
      S_INS_WALK:  if (ins_here) state_next = ts_pend ? S_TASK_EMIT : S_REPLY;
      S_TASK_EMIT: if (!res_valid && !emitted) state_next = S_IDLE;
      S_REPLY:     if (!res_valid) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      now       <= '0;
      head      <= NIL;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) status[i] <= ST_FREE;
      ts_pend   <= 1'b0;
      emitted   <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) cur <= in_item;
        end
        S_DISPATCH: begin
          ts_pend <= 1'b0;
          emitted <= 1'b0;
          guard   <= '0;
          unique case (cur.command)
            CMD_TICK: begin
              now <= now + 32'd1;
            end
            CMD_ALLOC: begin
              reply_ok   <= free_found;
              reply_slot <= free_found ? 5'(free_i) : 5'd0;
              if (free_found) status[free_i] <= ST_ALLOC;
            end
            default: begin
              is_arm     <= (cur.command == CMD_ARM);
              reply_slot <= cur.slot;
              reply_ok   <= slot_ok;
              tgt        <= cur_i;
              p          <= head;
              if (slot_ok && status[cur_i] == ST_ALLOC && cur.command == CMD_FREE)
                status[cur_i] <= ST_FREE;
              if (slot_ok && cur.command == CMD_ARM) begin
                dst[cur_i]      <= cur.destination;
                pay[cur_i]      <= cur.payload;
                deadline[cur_i] <= now + cur.delay_ticks;
                tdl             <= now + cur.delay_ticks;
              end
            end
          endcase
        end
        S_TICK_HEAD: begin
          // one expiry is held back in res so the final one can carry last
          if (!res_valid) begin
            if (head_due) begin
              if (hit_task) begin
                status[hi] <= ST_ALLOC;
                head    <= link[hi];
                guard   <= guard + LW'(1);
                ts_pend <= 1'b1;
              end else if (emitted) begin
                res_valid <= 1'b1;
                emitted   <= 1'b0;
              end else begin
                status[hi] <= ST_ALLOC;
                head    <= link[hi];
                guard   <= guard + LW'(1);
                res     <= '{KIND_EXPIRY, 5'(hi), 1'b1, dst[hi], pay[hi], 1'b0};
                emitted <= 1'b1;
              end
            end else if (ts_pend) begin
              tgt <= ts_i;
              deadline[ts_i] <= now + 32'd1;
              tdl <= now + 32'd1;
              status[ts_i] <= ST_RUN;
              is_arm <= 1'b0;
            end else if (emitted) begin
              res.last  <= 1'b1;
              res_valid <= 1'b1;
              emitted   <= 1'b0;
            end
          end
        end
        S_UNLINK: begin
          if (head == LW'(tgt)) head <= link[tgt];
          else if (p != NIL && q == LW'(tgt)) link[pi] <= link[tgt];
          else if (p != NIL) p <= q;
          if (unl_done && !is_arm) status[tgt] <= ST_FREE;
        end
        S_INS_START: begin
          if (is_arm) status[tgt] <= ST_RUN;
          if (ins_head) begin
            link[tgt] <= head;
            head <= LW'(tgt);
          end else p <= head;
        end
        S_INS_WALK: begin
          if (ins_here) begin
            link[pi]  <= LW'(tgt);
            link[tgt] <= q;
          end else p <= q;
        end
        S_TASK_EMIT: begin
          if (!res_valid) begin
            if (emitted) begin
              res_valid <= 1'b1;
              emitted   <= 1'b0;
            end else begin
              res <= '{KIND_TASK, task_slot, 1'b1, 4'd0, 8'd0, 1'b1};
              res_valid <= 1'b1;
            end
          end
        end
        S_REPLY: begin
          if (!res_valid) begin
            res <= '{KIND_REPLY, reply_slot, reply_ok, 4'd0, 8'd0, 1'b1};
            res_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/sorted_timer_list_manager_unit.sv
// sorted_timer_list_manager_unit: top level of the sorted timer list manager
// depends on stlm_pkg, stlm_fifo and stlm_engine
//
// keeps a 32-bit tick count and a pool of timer slots linked in a list sorted
// by deadline. commands enter a two-entry queue and are carried out one at a
// time by a sequencer that walks the list one link per cycle: a tick removes
// each expired timer from the head and walks the list to re-insert the task
// timer when it fires; allocate claims a free slot; free and arm unlink a
// running timer, and arm then inserts it by its new deadline. the sequencer
// takes the next command while the last result of the previous one still
// waits. each transaction on the result channel carries one result; last
// marks the final one of a command.
module sorted_timer_list_manager_unit
  import stlm_pkg::*;
#(
  parameter int NUM_SLOTS = DefNumSlots
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [4:0]  slot,
  input  logic [31:0] delay_ticks,
  input  logic [3:0]  destination,
  input  logic [7:0]  payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [4:0]  slot_out,
  output logic        ok,
  output logic [3:0]  dest_out,
  output logic [7:0]  payload_out,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic       task_en;
  logic [4:0] task_slot;
  item_t      in_item, q_item;
  logic       q_valid, q_ready;
  result_t    res;
  logic       busy;

  // configuration is always accepted
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      task_en   <= 1'b0;
      task_slot <= 5'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLE: task_en   <= cfg_data[0];
        CFG_SLOT:   task_slot <= cfg_data[4:0];
        default:    ;
      endcase
    end
  end

  assign in_item = '{cmd_t'(command), slot, delay_ticks, destination, payload};

  // front end: command queue
  stlm_fifo u_fifo (
    .clk, .rst,
    .in_valid (in_valid), .in_ready (in_ready), .in_item (in_item),
    .out_valid (q_valid), .out_ready (q_ready), .out_item (q_item)
  );

  // back end: list sequencer
  stlm_engine #(.NUM_SLOTS(NUM_SLOTS)) u_engine (
    .clk, .rst,
    .in_valid (q_valid), .in_ready (q_ready), .in_item (q_item),
    .task_en, .task_slot,
    .res_valid (out_valid), .res_ready (out_ready), .res (res), .busy (busy)
  );

  assign kind        = res.kind;
  assign slot_out    = res.slot_out;
  assign ok          = res.ok;
  assign dest_out    = res.dest_out;
  assign payload_out = res.payload_out;
  assign last        = res.last;

  // a result is only presented while the engine counts as busy
  a_busy: assert property (@(posedge clk) disable iff (rst) out_valid |-> busy)
    else $error("result without busy engine");
  // after a queue pop the engine is busy with the new command
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> busy)
    else $error("engine not busy after taking a command");

endmodule
